[rtl/texture_key_match_table_core_assert.svh]
// ----------------------------------------------------------------------------
// texture key match table assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TEXTURE_KEY_MATCH_TABLE_CORE_ASSERT_SVH
`define TEXTURE_KEY_MATCH_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// check held off while reset is high
`define TKM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("texture key table check failed");

// check that also holds through reset
`define TKM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("texture key table check failed");

`else

`define TKM_ASSERT(label, clk, rst, prop)
`define TKM_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[rtl/tkm_pkg.sv]
// ----------------------------------------------------------------------------
// tkm_pkg
// shared types and constants of the texture key match table
// ----------------------------------------------------------------------------
package tkm_pkg;

   // default table depth
   localparam int TABLE_DEPTH_DEF = 64;

   // field widths
   localparam int MODE_W  = 5;
   localparam int PAGE_W  = 12;
   localparam int PAL_W   = 16;
   localparam int X_W     = 10;
   localparam int Y_W     = 9;
   localparam int WIDTH_W = 11;
   localparam int HGT_W   = 10;
   localparam int CLS_W   = 2;
   localparam int STAT_W  = 3;
   localparam int INDEX_W = 6;
   localparam int USED_W  = 7;

   // key check limits
   localparam logic [MODE_W-1:0] MODE_4    = 5'd4;
   localparam logic [MODE_W-1:0] MODE_8    = 5'd8;
   localparam logic [MODE_W-1:0] MODE_16   = 5'd16;
   localparam logic [PAGE_W-1:0] PAGE_MAX  = 12'h9ff;
   localparam logic [11:0]       AREA_W    = 12'd1024;
   localparam logic [10:0]       AREA_H    = 11'd512;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_INVALID = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_DUP     = 3'd3,
      STAT_MISS    = 3'd4
   } status_type;

   // how a request ends
   typedef enum logic [2:0] {
      RES_CLEAR,
      RES_INVALID,
      RES_FULL,
      RES_DUP,
      RES_INSERT,
      RES_HIT,
      RES_MISS
   } res_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // stored key: id part then rectangle part
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PAGE_W-1:0]  page;
      logic [PAL_W-1:0]   palette;
      logic [CLS_W-1:0]   asset_class;
      logic [X_W-1:0]     x;
      logic [Y_W-1:0]     y;
      logic [WIDTH_W-1:0] width;
      logic [HGT_W-1:0]   height;
   } key_type;

   // controller to datapath
   typedef struct packed {
      logic         load;
      logic         scan_start;
      logic         scan_run;
      logic         finish;
      res_kind_type kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       key_ok;
      logic       lookup_ok;
      logic       hit;
      logic       scan_done;
      logic       out_free;
   } dp_status_type;

endpackage

[rtl/tkm_ctrl.sv]
// ----------------------------------------------------------------------------
// tkm_ctrl
// sequencer for clear, insert and lookup requests
// ----------------------------------------------------------------------------
module tkm_ctrl
   import tkm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   state_type    state_ff, state_in;
   res_kind_type kind_ff, kind_in;

   // state and pending result kind
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= RES_INVALID;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_run   = 1'b0;
      cmd.finish     = 1'b0;
      cmd.kind       = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            unique case (dp_status.op)
               OP_CLEAR: kind_in = RES_CLEAR;
               OP_INSERT: begin
                  priority if (dp_status.full) begin
                     kind_in = RES_FULL;
                  end else if (!dp_status.key_ok) begin
                     kind_in = RES_INVALID;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               OP_LOOKUP: begin
                  if (dp_status.lookup_ok) begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end else begin
                     kind_in = RES_MISS;
                  end
               end
               default: kind_in = RES_INVALID;
            endcase
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            priority if (dp_status.hit) begin
               kind_in  = (dp_status.op == OP_INSERT) ? RES_DUP : RES_HIT;
               state_in = ST_FINISH;
            end else if (dp_status.scan_done) begin
               kind_in  = (dp_status.op == OP_INSERT) ? RES_INSERT : RES_MISS;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (dp_status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/tkm_datapath.sv]
// ----------------------------------------------------------------------------
// tkm_datapath
// key register, key memory with scan pointer, entry count and response register
// ----------------------------------------------------------------------------
`include "texture_key_match_table_core_assert.svh"

module tkm_datapath
   import tkm_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request fields
   input  logic [1:0]         req_opcode,
   input  logic [MODE_W-1:0]  req_texture_mode,
   input  logic [PAGE_W-1:0]  req_texture_page,
   input  logic [PAL_W-1:0]   req_palette_id,
   input  logic [X_W-1:0]     req_rect_x,
   input  logic [Y_W-1:0]     req_rect_y,
   input  logic [WIDTH_W-1:0] req_rect_width,
   input  logic [HGT_W-1:0]   req_rect_height,
   input  logic [CLS_W-1:0]   req_asset_class,
   // register write
   input  logic               csr_valid,
   input  logic               csr_lookup_enable,
   // response
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [INDEX_W-1:0] rsp_entry_index,
   output logic [USED_W-1:0]  rsp_entries_used,
   // control
   input  cmd_type            cmd,
   output dp_status_type      dp_status
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   key_type              key_ff;
   logic [1:0]           op_ff;
   logic                 enable_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff;
   key_type              rd_data_ff;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic                 issue;
   logic                 match;
   logic                 key_ok;
   logic                 insert_done;
   logic [11:0]          x_end;
   logic [10:0]          y_end;
   logic                 rsp_valid_ff;
   logic [STAT_W-1:0]    status_ff;
   logic [INDEX_W-1:0]   index_ff;
   logic [USED_W-1:0]    used_ff;
   status_type           status_in;
   logic [IDX_W-1:0]     index_in;

   key_type mem_ff [TABLE_DEPTH];

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff              <= req_opcode;
         key_ff.mode        <= req_texture_mode;
         key_ff.page        <= req_texture_page;
         key_ff.palette     <= req_palette_id;
         key_ff.asset_class <= req_asset_class;
         key_ff.x           <= req_rect_x;
         key_ff.y           <= req_rect_y;
         key_ff.width       <= req_rect_width;
         key_ff.height      <= req_rect_height;
      end
   end

   // lookup enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_valid) begin
         enable_ff <= csr_lookup_enable;
      end
   end

   // insert key check, rectangle ends without wrap
   assign x_end  = {2'b00, key_ff.x} + {1'b0, key_ff.width};
   assign y_end  = {2'b00, key_ff.y} + {1'b0, key_ff.height};
   assign key_ok = ((key_ff.mode == MODE_4) || (key_ff.mode == MODE_8)
                    || (key_ff.mode == MODE_16))
                   && (key_ff.page <= PAGE_MAX)
                   && (key_ff.width != '0) && (key_ff.height != '0)
                   && (x_end <= AREA_W) && (y_end <= AREA_H);

   // scan pointer and read pipeline
   assign issue = cmd.scan_run && (ptr_ff < count_ff);
   assign match = (rd_data_ff == key_ff);

   always_comb begin
      ptr_in    = ptr_ff;
      rd_vld_in = issue;
      if (cmd.scan_start) begin
         ptr_in    = '0;
         rd_vld_in = 1'b0;
      end else if (issue) begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         ptr_ff    <= ptr_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // key memory read port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem_ff[ptr_ff[IDX_W-1:0]];
         rd_idx_ff  <= ptr_ff[IDX_W-1:0];
      end
   end

   // key memory write port, append at the fill count
   assign insert_done = cmd.finish && (cmd.kind == RES_INSERT);

   always_ff @(posedge clock) begin
      if (insert_done) begin
         mem_ff[count_ff[IDX_W-1:0]] <= key_ff;
      end
   end

   // first match of the scan
   always_ff @(posedge clock) begin
      if (cmd.scan_run && rd_vld_ff && match) begin
         hit_idx_ff <= rd_idx_ff;
      end
   end

   // result selection and entry count update
   always_comb begin
      count_in  = count_ff;
      index_in  = '0;
      status_in = STAT_INVALID;
      unique case (cmd.kind)
         RES_CLEAR: begin
            count_in  = '0;
            status_in = STAT_OK;
         end
         RES_INVALID: status_in = STAT_INVALID;
         RES_FULL:    status_in = STAT_FULL;
         RES_DUP:     status_in = STAT_DUP;
         RES_INSERT: begin
            count_in  = count_ff + 1'b1;
            index_in  = count_ff[IDX_W-1:0];
            status_in = STAT_OK;
         end
         RES_HIT: begin
            index_in  = hit_idx_ff;
            status_in = STAT_OK;
         end
         RES_MISS:    status_in = STAT_MISS;
         default:     status_in = STAT_INVALID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= count_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff <= status_in;
         index_ff  <= INDEX_W'(index_in);
         used_ff   <= USED_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_index  = index_ff;
   assign rsp_entries_used = used_ff;

   // status to the controller
   assign dp_status.op        = op_ff;
   assign dp_status.full      = (count_ff >= DEPTH_CNT);
   assign dp_status.key_ok    = key_ok;
   assign dp_status.lookup_ok = enable_ff && (count_ff != '0);
   assign dp_status.hit       = rd_vld_ff && match;
   assign dp_status.scan_done = !issue && !rd_vld_ff;
   assign dp_status.out_free  = !rsp_valid_ff || rsp_ready;

   // checks
   `TKM_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_CNT)
   `TKM_ASSERT(a_read_in_range, clock, reset, rd_vld_ff |-> (CNT_W'(rd_idx_ff) < count_ff))
   `TKM_ASSERT(a_finish_slot_free, clock, reset, cmd.finish |-> (!rsp_valid_ff || rsp_ready))
   `TKM_ASSERT(a_insert_grows, clock, reset, insert_done |=> (count_ff == $past(count_ff) + 1'b1))

endmodule

[rtl/texture_key_match_table_core.sv]
// ----------------------------------------------------------------------------
// texture_key_match_table_core
// exact-match table of texture source keys with clear, insert and lookup
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel carries an opcode and a full key
// and yields exactly one response on the rsp_ channel (status, entry index,
// entries used). Clear and the requests that need no scan (insert into a
// full table, invalid key, unused opcode, disabled or empty lookup) go
// from the decide step straight to the response. Insert and lookup scan
// the stored keys in order through one registered memory read port, one
// entry per cycle; the scan ends at the first hit or after the last stored
// entry, and the response is loaded once the output register is free.
// One request is in work at a time; the next is accepted in the cycle after
// the response is loaded into the output register, even if the receiver has
// not taken it yet. A stalled receiver holds the response and, once the next
// request is done, holds off the one after it.
// The csr_ channel writes lookup_enable; it is always ready and is meant
// to be written while the table is idle. Reset empties the table (entry
// count zero) and clears lookup_enable; the key memory is not cleared and
// needs no clearing pass.
// ----------------------------------------------------------------------------
module texture_key_match_table_core
   import tkm_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [MODE_W-1:0]  req_texture_mode,
   input  logic [PAGE_W-1:0]  req_texture_page,
   input  logic [PAL_W-1:0]   req_palette_id,
   input  logic [X_W-1:0]     req_rect_x,
   input  logic [Y_W-1:0]     req_rect_y,
   input  logic [WIDTH_W-1:0] req_rect_width,
   input  logic [HGT_W-1:0]   req_rect_height,
   input  logic [CLS_W-1:0]   req_asset_class,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [INDEX_W-1:0] rsp_entry_index,
   output logic [USED_W-1:0]  rsp_entries_used,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_lookup_enable
);

   cmd_type       cmd;
   dp_status_type dp_status;

   // register writes complete at once
   assign csr_ready = 1'b1;

   // controller
   tkm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // datapath
   tkm_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_texture_mode  (req_texture_mode),
      .req_texture_page  (req_texture_page),
      .req_palette_id    (req_palette_id),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_width    (req_rect_width),
      .req_rect_height   (req_rect_height),
      .req_asset_class   (req_asset_class),
      .csr_valid         (csr_valid),
      .csr_lookup_enable (csr_lookup_enable),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_entries_used  (rsp_entries_used),
      .cmd               (cmd),
      .dp_status         (dp_status)
   );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// texture key match table testbench
// Drives clear, insert, lookup and unused-opcode requests with random idle
// cycles on both channels. Every response field is checked against a
// behavioral key table copy's prediction, or a typed row's listed value.
// ----------------------------------------------------------------------------
module tb;
   import tkm_pkg::*;

   localparam int BANK_DEPTH     = TABLE_DEPTH_DEF;
   localparam int RANDOM_ITEMS   = 1850;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int ENABLE_ROW     = 16;
   localparam int MAX_PRINTS     = 100;
   // opcode value that the block does not define
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] entry_index;
      logic [USED_W-1:0]  entries_used;
   } table_answer_type;

   typedef struct {
      logic [1:0]       op;
      key_type          key;
      bit               typed;
      table_answer_type want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic [MODE_W-1:0]  req_texture_mode;
   logic [PAGE_W-1:0]  req_texture_page;
   logic [PAL_W-1:0]   req_palette_id;
   logic [X_W-1:0]     req_rect_x;
   logic [Y_W-1:0]     req_rect_y;
   logic [WIDTH_W-1:0] req_rect_width;
   logic [HGT_W-1:0]   req_rect_height;
   logic [CLS_W-1:0]   req_asset_class;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [STAT_W-1:0]  rsp_status;
   logic [INDEX_W-1:0] rsp_entry_index;
   logic [USED_W-1:0]  rsp_entries_used;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_lookup_enable;

   // key table copy kept by the predictor
   key_type          key_bank [BANK_DEPTH];
   int               bank_used;
   bit               bank_lookup_en;
   table_answer_type answers_due [$];
   stim_row_type     stim_table [$];

   bit steady;
   bit squeeze_req;
   int mismatches;
   int quiet_cycles;
   int requests_sent;
   int clears_seen;
   int stored_seen;
   int full_seen;
   int hits_seen;
   int enable_writes;

   texture_key_match_table_core #(
      .TABLE_DEPTH(BANK_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_texture_mode(req_texture_mode),
      .req_texture_page(req_texture_page),
      .req_palette_id(req_palette_id),
      .req_rect_x(req_rect_x),
      .req_rect_y(req_rect_y),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .req_asset_class(req_asset_class),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_entry_index(rsp_entry_index),
      .rsp_entries_used(rsp_entries_used),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_lookup_enable(csr_lookup_enable)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mismatch report, printing capped to keep the log short
   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      if (mismatches < MAX_PRINTS)
         $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // first stored entry equal to the key
   function automatic bit find_key(input key_type k, output int slot);
      slot = 0;
      for (int i = 0; i < bank_used && i < BANK_DEPTH; i++) begin
         if (key_bank[i] == k) begin
            slot = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // apply one request to the table copy and return the response it gives
   function automatic table_answer_type apply_to_table(input logic [1:0] op, input key_type k);
      table_answer_type a;
      int               slot;
      bit               fits;
      a = '0;
      a.status = STAT_INVALID;
      fits = (k.mode == MODE_4 || k.mode == MODE_8 || k.mode == MODE_16) &&
             k.page <= PAGE_MAX && k.width != '0 && k.height != '0 &&
             int'(k.x) + int'(k.width) <= int'(AREA_W) &&
             int'(k.y) + int'(k.height) <= int'(AREA_H);
      case (op)
         OP_CLEAR: begin
            bank_used = 0;
            a.status = STAT_OK;
            clears_seen++;
         end
         OP_INSERT: begin
            // full wins over invalid, invalid over duplicate
            if (bank_used >= BANK_DEPTH) begin
               a.status = STAT_FULL;
               full_seen++;
            end else if (!fits) begin
               a.status = STAT_INVALID;
            end else if (find_key(k, slot)) begin
               a.status = STAT_DUP;
            end else begin
               key_bank[bank_used] = k;
               a.entry_index = INDEX_W'(bank_used);
               bank_used++;
               a.status = STAT_OK;
               stored_seen++;
            end
         end
         OP_LOOKUP: begin
            a.status = STAT_MISS;
            if (bank_lookup_en && bank_used != 0 && find_key(k, slot)) begin
               a.status = STAT_OK;
               a.entry_index = INDEX_W'(slot);
               hits_seen++;
            end
         end
         default: ;
      endcase
      a.entries_used = USED_W'(bank_used);
      return a;
   endfunction

   function automatic key_type make_key(
      input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] page,
      input logic [PAL_W-1:0] palette, input logic [CLS_W-1:0] asset_class,
      input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
      input logic [WIDTH_W-1:0] width, input logic [HGT_W-1:0] height);
      key_type k;
      k.mode = mode;
      k.page = page;
      k.palette = palette;
      k.asset_class = asset_class;
      k.x = x;
      k.y = y;
      k.width = width;
      k.height = height;
      return k;
   endfunction

   // random key that passes the insert checks
   function automatic key_type fresh_key();
      key_type k;
      case ($urandom_range(0, 2))
         0: k.mode = MODE_4;
         1: k.mode = MODE_8;
         default: k.mode = MODE_16;
      endcase
      k.page = PAGE_W'($urandom_range(0, int'(PAGE_MAX)));
      k.palette = PAL_W'($urandom);
      k.asset_class = CLS_W'($urandom);
      k.x = X_W'($urandom);
      k.y = Y_W'($urandom);
      // hug the right and bottom edges now and then
      k.width = WIDTH_W'(($urandom_range(0, 3) == 0) ? 1024 - int'(k.x) :
                         $urandom_range(1, 1024 - int'(k.x)));
      k.height = HGT_W'(($urandom_range(0, 3) == 0) ? 512 - int'(k.y) :
                        $urandom_range(1, 512 - int'(k.y)));
      return k;
   endfunction

   function automatic void add_row(input logic [1:0] op, input key_type k, input bit typed,
                                   input status_type st, input int idx, input int used);
      stim_row_type r;
      r.op = op;
      r.key = k;
      r.typed = typed;
      r.want.status = st;
      r.want.entry_index = INDEX_W'(idx);
      r.want.entries_used = USED_W'(used);
      stim_table.push_back(r);
   endfunction

   // offer one request, hold it until taken, then queue its response
   task automatic send_req(input logic [1:0] op, input key_type k, input bit typed,
                           input table_answer_type want);
      int               gap;
      table_answer_type predicted;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_texture_mode <= k.mode;
      req_texture_page <= k.page;
      req_palette_id <= k.palette;
      req_rect_x <= k.x;
      req_rect_y <= k.y;
      req_rect_width <= k.width;
      req_rect_height <= k.height;
      req_asset_class <= k.asset_class;
      do @(posedge clock); while (!req_ready);
      predicted = apply_to_table(op, k);
      answers_due.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   // register write once the table has gone idle
   task automatic write_enable(input bit value);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_lookup_enable <= value;
      do @(posedge clock); while (!csr_ready);
      bank_lookup_en = value;
      enable_writes++;
      csr_valid <= 1'b0;
   endtask

   // request side: directed table, then random phases
   initial begin : stimulus
      key_type                     key_a;
      key_type                     key_b;
      key_type                     key_c;
      key_type                     key_ones;
      key_type                     k;
      table_answer_type            blank;
      logic [$bits(key_type)-1:0]  raw;
      bit [95:0]                   spray;
      int                          n;
      int                          m;
      int                          pick;
      int                          b;
      int                          kind;
      int                          phase;
      blank = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_CLEAR;
      req_texture_mode <= '0;
      req_texture_page <= '0;
      req_palette_id <= '0;
      req_rect_x <= '0;
      req_rect_y <= '0;
      req_rect_width <= '0;
      req_rect_height <= '0;
      req_asset_class <= '0;
      csr_valid <= 1'b0;
      csr_lookup_enable <= 1'b0;

      key_a = make_key(MODE_4, '0, '0, '0, '0, '0, 11'd1, 10'd1);
      key_b = make_key(MODE_16, PAGE_MAX, 16'hffff, 2'd3, '0, '0, 11'd1024, 10'd512);
      key_c = make_key(MODE_8, 12'h123, 16'h5a5a, 2'd2, 10'd1023, 9'd511, 11'd1, 10'd1);
      key_ones = make_key('1, '1, '1, '1, '1, '1, '1, '1);

      // directed rows, lookup disabled until ENABLE_ROW
      add_row(OP_LOOKUP, key_a, 1, STAT_MISS, 0, 0);
      add_row(OP_INSERT, key_a, 1, STAT_OK, 0, 1);
      add_row(OP_LOOKUP, key_a, 1, STAT_MISS, 0, 1);
      add_row(OP_INSERT, key_a, 1, STAT_DUP, 0, 1);
      add_row(OP_INSERT, make_key('0, '0, '0, '0, '0, '0, '0, '0), 1, STAT_INVALID, 0, 1);
      add_row(OP_INSERT, make_key(MODE_8, 12'ha00, '0, '0, '0, '0, 11'd4, 10'd4),
              1, STAT_INVALID, 0, 1);
      add_row(OP_INSERT, make_key(MODE_8, '0, '0, '0, '0, '0, '0, 10'd4), 1, STAT_INVALID, 0, 1);
      add_row(OP_INSERT, make_key(MODE_8, '0, '0, '0, '0, '0, 11'd4, '0), 1, STAT_INVALID, 0, 1);
      add_row(OP_INSERT, make_key(MODE_4, '0, '0, '0, 10'd1023, '0, 11'd2, 10'd1),
              1, STAT_INVALID, 0, 1);
      add_row(OP_INSERT, make_key(MODE_4, '0, '0, '0, '0, 9'd511, 11'd1, 10'd2),
              1, STAT_INVALID, 0, 1);
      add_row(OP_UNUSED, key_b, 1, STAT_INVALID, 0, 1);
      add_row(OP_INSERT, key_b, 1, STAT_OK, 1, 2);
      add_row(OP_INSERT, key_c, 1, STAT_OK, 2, 3);
      add_row(OP_INSERT, key_ones, 1, STAT_INVALID, 0, 3);
      add_row(OP_LOOKUP, key_ones, 1, STAT_MISS, 0, 3);
      add_row(OP_CLEAR, key_ones, 1, STAT_OK, 0, 0);
      add_row(OP_LOOKUP, key_a, 1, STAT_MISS, 0, 0);
      add_row(OP_INSERT, key_a, 1, STAT_OK, 0, 1);
      add_row(OP_INSERT, key_b, 1, STAT_OK, 1, 2);
      add_row(OP_LOOKUP, key_b, 1, STAT_OK, 1, 2);
      add_row(OP_LOOKUP, key_ones, 0, STAT_OK, 0, 0);
      add_row(OP_LOOKUP, make_key(MODE_4, '0, '0, 2'd1, '0, '0, 11'd1, 10'd1), 0, STAT_OK, 0, 0);
      add_row(OP_CLEAR, key_a, 1, STAT_OK, 0, 0);
      add_row(OP_INSERT, key_c, 1, STAT_OK, 0, 1);
      add_row(OP_LOOKUP, key_c, 1, STAT_OK, 0, 1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (i == ENABLE_ROW) write_enable(1'b1);
         send_req(stim_table[i].op, stim_table[i].key, stim_table[i].typed, stim_table[i].want);
      end

      // random phases: mostly clear, load, then look up; some noise
      phase = 0;
      while (requests_sent < stim_table.size() + RANDOM_ITEMS) begin
         kind = (phase == 1) ? 0 : $urandom_range(0, 9);
         write_enable((phase == 1) ? 1'b1 : ($urandom_range(0, 3) != 0));
         steady = (phase != 1) && ($urandom_range(0, 3) == 0);
         if (kind < 7) begin
            send_req(OP_CLEAR, fresh_key(), 0, blank);
            // one long receiver stall while a load is streaming
            if (phase == 1) squeeze_req = 1'b1;
            n = (phase == 1) ? 40 :
                ($urandom_range(0, 4) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 40);
            for (int j = 0; j < n; j++) begin
               pick = $urandom_range(0, 15);
               k = fresh_key();
               if (pick == 0 && bank_used != 0) begin
                  k = key_bank[$urandom_range(0, bank_used - 1)];
               end else if (pick == 1) begin
                  // break one insert rule
                  case ($urandom_range(0, 5))
                     0: k.mode = MODE_W'($urandom_range(0, 31));
                     1: k.page = PAGE_W'($urandom_range(int'(PAGE_MAX) + 1, 4095));
                     2: k.width = '0;
                     3: k.height = '0;
                     4: k.width = WIDTH_W'($urandom_range(1025 - int'(k.x), 2047));
                     default: k.height = HGT_W'($urandom_range(513 - int'(k.y), 1023));
                  endcase
               end
               send_req(OP_INSERT, k, 0, blank);
            end
            m = $urandom_range(4, 24);
            for (int j = 0; j < m; j++) begin
               pick = $urandom_range(0, 9);
               k = fresh_key();
               if (pick < 6 && bank_used != 0) begin
                  k = key_bank[$urandom_range(0, bank_used - 1)];
               end else if (pick < 8 && bank_used != 0) begin
                  // stored key with one bit flipped
                  raw = key_bank[$urandom_range(0, bank_used - 1)];
                  b = $urandom_range(0, $bits(key_type) - 1);
                  raw[b] = ~raw[b];
                  k = raw;
               end
               send_req(OP_LOOKUP, k, 0, blank);
            end
         end else begin
            for (int j = 0; j < 20; j++) begin
               spray = {$urandom, $urandom, $urandom};
               k = spray[$bits(key_type)-1:0];
               send_req(2'($urandom), k, 0, blank);
            end
         end
         phase++;
      end
      req_valid <= 1'b0;

      // drain and settle
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests: %0d clears, %0d keys stored, %0d full rejections, %0d hits",
               requests_sent, clears_seen, stored_seen, full_seen, hits_seen);
      $display("lookup_enable written %0d times, %0d mismatches", enable_writes, mismatches);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // response side with random stalls and one long hold-off
   initial begin : receiver
      int stall;
      bit squeezed;
      squeezed = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze_req && !squeezed) begin
            stall = SQUEEZE_CYCLES;
            squeezed = 1'b1;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each response with the oldest queued expected response
   always @(posedge clock) begin : check_answers
      table_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            report("response with no request pending", rsp_status, 0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_status !== want.status)
               report("status", rsp_status, want.status);
            if (rsp_entry_index !== want.entry_index)
               report("entry_index", rsp_entry_index, want.entry_index);
            if (rsp_entries_used !== want.entries_used)
               report("entries_used", rsp_entries_used, want.entries_used);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses pending",
                     WATCHDOG_LIMIT, answers_due.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule

[sim.f]
+incdir+rtl
rtl/tkm_pkg.sv
rtl/tkm_ctrl.sv
rtl/tkm_datapath.sv
rtl/texture_key_match_table_core.sv
dv/tb.sv
